// File: rtl/dpfa_pkg.sv
// ----------------------------------------------------------------------------
// dpfa_pkg
// Shared types and constants of the demand-paging frame allocator.
// ----------------------------------------------------------------------------
package dpfa_pkg;

    localparam int CMD_W       = 2;
    localparam int PROCESS_W   = 4;
    localparam int KEY_W       = 21;
    localparam int LEN_W       = 21;
    localparam int COUNT_W     = 5;
    localparam int FREE_LEFT_W = 14;

    localparam int TABLE_ENTRIES     = 2048;
    localparam int ELEMENTS_PER_PAGE = 1024;
    localparam int PAGE_W            = $clog2(TABLE_ENTRIES);
    localparam int PAGE_SHIFT        = $clog2(ELEMENTS_PER_PAGE);

    localparam logic [CMD_W-1:0] CMD_SEARCH  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_MAP     = 2'd2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SEARCH,
        ST_MAP,
        ST_CHECK,
        ST_REL_RD,
        ST_REL_WR,
        ST_DONE
    } state_t;

endpackage

// File: rtl/dpfa_div.sv
// ----------------------------------------------------------------------------
// dpfa_div
// Element index to page-table slot: shift, mask and add RESIDENT_PAGES.
// ----------------------------------------------------------------------------
module dpfa_div
    import dpfa_pkg::*;
#(
    parameter int RESIDENT_PAGES = 10
)
(
    input  logic [KEY_W-1:0]  elem_index,
    output logic [PAGE_W-1:0] page
);

    logic [KEY_W-1:0] page_num;

    assign page_num = elem_index >> PAGE_SHIFT;
    assign page     = page_num[PAGE_W-1:0] + PAGE_W'(RESIDENT_PAGES);

endmodule

// File: rtl/demand_paging_frame_allocator_core.sv
// ----------------------------------------------------------------------------
// demand_paging_frame_allocator_core
// Per-process page tables and a shared free-frame stack, both in memories.
//
// Channel  Direction  Handshake           Fields
// in       input      in_valid/in_stall   cmd, process, target_index, array_length
// out      output     out_valid/out_stall status, probes, faults, free_left
//
// After reset a clearing pass over max(PROCESSES*TABLE_ENTRIES, FRAMES)
// addresses initializes both memories; no item is taken during it.
// One item is worked on at a time. Each of a search's at most 21 probes reads
// an entry and writes back a missing page; a release reads all TABLE_ENTRIES
// entries and frees each mapped one; a resident map checks each of its pages.
// A held result does not block the next item from being accepted.
// ----------------------------------------------------------------------------
module demand_paging_frame_allocator_core
    import dpfa_pkg::*;
#(
    parameter int PROCESSES      = 16,
    parameter int FRAMES         = 12288,
    parameter int RESIDENT_PAGES = 10
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [CMD_W-1:0]       cmd,
    input  logic [PROCESS_W-1:0]   process,
    input  logic [KEY_W-1:0]       target_index,
    input  logic [LEN_W-1:0]       array_length,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   status,
    output logic [COUNT_W-1:0]     probes,
    output logic [COUNT_W-1:0]     faults,
    output logic [FREE_LEFT_W-1:0] free_left
);

    localparam int PT_DEPTH = PROCESSES * TABLE_ENTRIES;
    localparam int AW       = $clog2(PT_DEPTH);
    localparam int SW       = $clog2(FRAMES);
    localparam int PW       = SW + 1;
    localparam int CW       = $clog2(FRAMES + 1);
    localparam int TW       = $clog2(TABLE_ENTRIES);
    localparam int CLR_N    = (PT_DEPTH > FRAMES) ? PT_DEPTH : FRAMES;
    localparam int CLRW     = $clog2(CLR_N);
    localparam int NRES     = (RESIDENT_PAGES < TABLE_ENTRIES) ? RESIDENT_PAGES
                                                               : TABLE_ENTRIES;

    logic [PW-1:0] pt_mem [PT_DEPTH];
    logic [SW-1:0] stk_mem [FRAMES];

    state_t state_reg, state_next;
    logic [CLRW-1:0]    clr_reg, clr_next;
    logic [CW-1:0]      free_reg, free_next;
    logic [KEY_W-1:0]   left_reg, left_next;
    logic [KEY_W-1:0]   right_reg, right_next;
    logic [KEY_W-1:0]   mid_reg, mid_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [CMD_W-1:0]   cmd_reg, cmd_next;
    logic [AW-1:0]      base_reg, base_next;
    logic [AW-1:0]      addr_reg, addr_next;
    logic [TW-1:0]      idx_reg, idx_next;
    logic [COUNT_W-1:0] probes_reg, probes_next;
    logic [COUNT_W-1:0] faults_reg, faults_next;
    logic               status_reg, status_next;

    logic                   out_valid_reg, out_valid_next;
    logic                   out_status_reg;
    logic [COUNT_W-1:0]     out_probes_reg;
    logic [COUNT_W-1:0]     out_faults_reg;
    logic [FREE_LEFT_W-1:0] out_free_reg;
    logic                   out_load;

    logic          pt_we, pt_re;
    logic [AW-1:0] pt_waddr, pt_raddr;
    logic [PW-1:0] pt_wdata, pt_rdata_reg;
    logic          stk_we, stk_re;
    logic [SW-1:0] stk_waddr, stk_raddr, stk_wdata, stk_rdata_reg;

    logic [KEY_W:0]   mid_sum;
    logic [TW-1:0]    probe_page;
    logic             in_accept;

    dpfa_div #(.RESIDENT_PAGES(RESIDENT_PAGES)) u_page
    (
        .elem_index (mid_sum[KEY_W:1]),
        .page       (probe_page)
    );

    always_ff @(posedge clk)
    begin
        if (pt_we)
            pt_mem[pt_waddr] <= pt_wdata;
        if (pt_re)
            pt_rdata_reg <= pt_mem[pt_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
            stk_mem[stk_waddr] <= stk_wdata;
        if (stk_re)
            stk_rdata_reg <= stk_mem[stk_raddr];
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign mid_sum   = {1'b0, left_reg} + {1'b0, right_reg};
    assign stk_raddr = SW'(free_reg - CW'(1));

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        free_next   = free_reg;
        left_next   = left_reg;
        right_next  = right_reg;
        mid_next    = mid_reg;
        key_next    = key_reg;
        cmd_next    = cmd_reg;
        base_next   = base_reg;
        addr_next   = addr_reg;
        idx_next    = idx_reg;
        probes_next = probes_reg;
        faults_next = faults_reg;
        status_next = status_reg;
        out_load    = 1'b0;
        pt_we       = 1'b0;
        pt_waddr    = addr_reg;
        pt_wdata    = '0;
        pt_re       = 1'b0;
        pt_raddr    = addr_reg;
        stk_we      = 1'b0;
        stk_waddr   = free_reg[SW-1:0];
        stk_wdata   = pt_rdata_reg[SW-1:0];
        stk_re      = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (32'(clr_reg) < PT_DEPTH)
                begin
                    pt_we    = 1'b1;
                    pt_waddr = clr_reg[AW-1:0];
                end
                if (32'(clr_reg) < FRAMES)
                begin
                    stk_we    = 1'b1;
                    stk_waddr = clr_reg[SW-1:0];
                    stk_wdata = clr_reg[SW-1:0];
                end
                clr_next = clr_reg + CLRW'(1);
                if (clr_reg == CLRW'(CLR_N - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    cmd_next    = cmd;
                    key_next    = target_index;
                    base_next   = AW'(process * TABLE_ENTRIES);
                    idx_next    = '0;
                    left_next   = '0;
                    right_next  = array_length - LEN_W'(1);
                    probes_next = '0;
                    faults_next = '0;
                    status_next = 1'b0;
                    if (32'(process) >= PROCESSES)
                        state_next = ST_DONE;
                    else if (cmd == CMD_SEARCH)
                        state_next = (array_length > LEN_W'(1)) ? ST_SEARCH : ST_DONE;
                    else if (cmd == CMD_RELEASE)
                        state_next = ST_REL_RD;
                    else if (cmd == CMD_MAP)
                        state_next = (NRES > 0) ? ST_MAP : ST_DONE;
                    else
                        state_next = ST_DONE;
                end
            end
            ST_SEARCH:
            begin
                mid_next   = mid_sum[KEY_W:1];
                addr_next  = base_reg + AW'(probe_page);
                pt_re      = 1'b1;
                pt_raddr   = addr_next;
                stk_re     = 1'b1;
                state_next = ST_CHECK;
            end
            ST_MAP:
            begin
                addr_next  = base_reg + AW'(idx_reg);
                pt_re      = 1'b1;
                pt_raddr   = addr_next;
                stk_re     = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (cmd_reg == CMD_SEARCH)
                    probes_next = (probes_reg == COUNT_MAX) ? COUNT_MAX
                                                            : probes_reg + COUNT_W'(1);
                if (!pt_rdata_reg[SW] && cmd_reg == CMD_SEARCH)
                    faults_next = (faults_reg == COUNT_MAX) ? COUNT_MAX
                                                            : faults_reg + COUNT_W'(1);
                if (!pt_rdata_reg[SW] && free_reg == '0)
                begin
                    status_next = 1'b1;
                    state_next  = ST_DONE;
                end
                else
                begin
                    if (!pt_rdata_reg[SW])
                    begin
                        pt_we     = 1'b1;
                        pt_wdata  = {1'b1, stk_rdata_reg};
                        free_next = free_reg - CW'(1);
                    end
                    if (cmd_reg == CMD_SEARCH)
                    begin
                        if (key_reg <= mid_reg)
                            right_next = mid_reg;
                        else
                            left_next = mid_reg + KEY_W'(1);
                        state_next = (left_next < right_next) ? ST_SEARCH : ST_DONE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + TW'(1);
                        state_next = (idx_reg == TW'(NRES - 1)) ? ST_DONE : ST_MAP;
                    end
                end
            end
            ST_REL_RD:
            begin
                addr_next  = base_reg + AW'(idx_reg);
                pt_re      = 1'b1;
                pt_raddr   = addr_next;
                state_next = ST_REL_WR;
            end
            ST_REL_WR:
            begin
                if (pt_rdata_reg[SW])
                begin
                    pt_we = 1'b1;
                    if (32'(free_reg) < FRAMES)
                    begin
                        stk_we    = 1'b1;
                        free_next = free_reg + CW'(1);
                    end
                end
                idx_next   = idx_reg + TW'(1);
                state_next = (idx_reg == TW'(TABLE_ENTRIES - 1)) ? ST_DONE : ST_REL_RD;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        if (out_load)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            free_reg      <= CW'(FRAMES);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            free_reg      <= free_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        left_reg   <= left_next;
        right_reg  <= right_next;
        mid_reg    <= mid_next;
        key_reg    <= key_next;
        cmd_reg    <= cmd_next;
        base_reg   <= base_next;
        addr_reg   <= addr_next;
        idx_reg    <= idx_next;
        probes_reg <= probes_next;
        faults_reg <= faults_next;
        status_reg <= status_next;
        if (out_load)
        begin
            out_status_reg <= status_reg;
            out_probes_reg <= probes_reg;
            out_faults_reg <= faults_reg;
            out_free_reg   <= FREE_LEFT_W'(free_reg);
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign probes    = out_probes_reg;
    assign faults    = out_faults_reg;
    assign free_left = out_free_reg;

endmodule

// File: rtl/dpfa_checker.sv
// ----------------------------------------------------------------------------
// dpfa_checker
// Port-level checks of the frame allocator, bound to the top level.
// ----------------------------------------------------------------------------
module dpfa_checker
    import dpfa_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_stall,
    input logic                   out_valid,
    input logic                   out_stall,
    input logic                   status,
    input logic [COUNT_W-1:0]     probes,
    input logic [COUNT_W-1:0]     faults,
    input logic [FREE_LEFT_W-1:0] free_left
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("Result item dropped while stalled.");

    a_free_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(free_left) && $stable(status))
        else $error("Stalled result item changed.");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("Second item accepted while one is at work.");

    a_faults: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> faults <= probes)
        else $error("More faults than probes reported.");

endmodule

bind demand_paging_frame_allocator_core dpfa_checker u_dpfa_checker (.*);

// File: verif/demand_paging_frame_allocator_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Demand-paging frame allocator testbench
// Drives searches, releases, resident maps and unused commands into the core.
// Each result is checked against a behavioral model of the page tables and
// the free-frame stack. One phase runs the stack dry, then releases it again.
// ----------------------------------------------------------------------------
module demand_paging_frame_allocator_core_tb;
    import dpfa_pkg::*;

    localparam int N_PROC     = 16;
    localparam int N_ENTRIES  = 2048;
    localparam int N_FRAMES   = 12288;
    localparam int N_RESIDENT = 10;
    localparam int PAGE_ELEMS = 1024;
    localparam int WATCHDOG   = 200000;
    localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;
    localparam logic [LEN_W-1:0] LEN_MAX = 21'd2086912;

    typedef struct {
        logic                   st;
        logic [COUNT_W-1:0]     pr;
        logic [COUNT_W-1:0]     fa;
        logic [FREE_LEFT_W-1:0] fl;
    } alloc_result_t;

    typedef struct {
        logic [CMD_W-1:0]     c;
        logic [PROCESS_W-1:0] p;
        logic [KEY_W-1:0]     k;
        logic [LEN_W-1:0]     n;
        bit                   fixed;
        alloc_result_t        r;
    } request_t;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic [CMD_W-1:0]       cmd;
    logic [PROCESS_W-1:0]   process;
    logic [KEY_W-1:0]       target_index;
    logic [LEN_W-1:0]       array_length;
    logic                   out_valid;
    logic                   out_stall;
    logic                   status;
    logic [COUNT_W-1:0]     probes;
    logic [COUNT_W-1:0]     faults;
    logic [FREE_LEFT_W-1:0] free_left;

    bit                  page_valid [N_PROC*N_ENTRIES];
    logic [13:0]         page_frame [N_PROC*N_ENTRIES];
    logic [13:0]         free_stack [N_FRAMES];
    int                  frames_avail;
    alloc_result_t       pending_results [$];
    request_t            cur_req;
    int                  errors;
    int                  idle_cycles;
    int                  send_idle_pct;
    int                  stall_pct;
    bit                  hold_req;
    int                  n_items;
    int                  n_results;
    int                  n_exhausted;

    demand_paging_frame_allocator_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .process      (process),
        .target_index (target_index),
        .array_length (array_length),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .probes       (probes),
        .faults       (faults),
        .free_left    (free_left)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic alloc_result_t allocate_pages(input request_t q);
        alloc_result_t r;
        int lo;
        int hi;
        int md;
        int idx;
        int np;
        int nf;
        logic st;
        st = 1'b0;
        np = 0;
        nf = 0;
        if (q.c == CMD_SEARCH)
        begin
            lo = 0;
            hi = int'(q.n) - 1;
            while (lo < hi && !st)
            begin
                md = (lo + hi) / 2;
                idx = int'(q.p) * N_ENTRIES + (N_RESIDENT + md / PAGE_ELEMS) % N_ENTRIES;
                np++;
                if (!page_valid[idx])
                begin
                    nf++;
                    if (frames_avail == 0)
                        st = 1'b1;
                    else
                    begin
                        frames_avail--;
                        page_frame[idx] = free_stack[frames_avail];
                        page_valid[idx] = 1'b1;
                    end
                end
                if (int'(q.k) <= md)
                    hi = md;
                else
                    lo = md + 1;
            end
        end
        else if (q.c == CMD_RELEASE)
        begin
            for (int i = 0; i < N_ENTRIES; i++)
            begin
                idx = int'(q.p) * N_ENTRIES + i;
                if (page_valid[idx])
                begin
                    if (frames_avail < N_FRAMES)
                    begin
                        free_stack[frames_avail] = page_frame[idx];
                        frames_avail++;
                    end
                    page_valid[idx] = 1'b0;
                end
            end
        end
        else if (q.c == CMD_MAP)
        begin
            for (int i = 0; i < N_RESIDENT && !st; i++)
            begin
                idx = int'(q.p) * N_ENTRIES + i;
                if (!page_valid[idx])
                begin
                    if (frames_avail == 0)
                        st = 1'b1;
                    else
                    begin
                        frames_avail--;
                        page_frame[idx] = free_stack[frames_avail];
                        page_valid[idx] = 1'b1;
                    end
                end
            end
        end
        r.st = st;
        r.pr = (np > 31) ? COUNT_MAX : COUNT_W'(np);
        r.fa = (nf > 31) ? COUNT_MAX : COUNT_W'(nf);
        r.fl = FREE_LEFT_W'(frames_avail);
        return r;
    endfunction

    always @(posedge clk)
    begin
        alloc_result_t want;
        alloc_result_t got;
        if (rst_n)
        begin
            idle_cycles = idle_cycles + 1;
            if (in_valid && !in_stall)
            begin
                idle_cycles = 0;
                want = allocate_pages(cur_req);
                if (cur_req.fixed)
                    want = cur_req.r;
                pending_results.push_back(want);
                n_items++;
            end
            if (out_valid && !out_stall)
            begin
                idle_cycles = 0;
                got.st = status;
                got.pr = probes;
                got.fa = faults;
                got.fl = free_left;
                n_results++;
                if (got.st)
                    n_exhausted++;
                if (pending_results.size() == 0)
                begin
                    $display("%0t: result with nothing expected: %0d %0d %0d %0d",
                             $time, got.st, got.pr, got.fa, got.fl);
                    errors++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.st !== want.st)
                    begin
                        $display("%0t: status expected %0d actual %0d", $time, want.st, got.st);
                        errors++;
                    end
                    if (got.pr !== want.pr)
                    begin
                        $display("%0t: probes expected %0d actual %0d", $time, want.pr, got.pr);
                        errors++;
                    end
                    if (got.fa !== want.fa)
                    begin
                        $display("%0t: faults expected %0d actual %0d", $time, want.fa, got.fa);
                        errors++;
                    end
                    if (got.fl !== want.fl)
                    begin
                        $display("%0t: free_left expected %0d actual %0d",
                                 $time, want.fl, got.fl);
                        errors++;
                    end
                end
            end
            if (idle_cycles >= WATCHDOG)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        int held;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                held = 0;
                while (held < 3000)
                begin
                    out_stall <= 1'b1;
                    @(negedge clk);
                    held++;
                end
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic send(input request_t q);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        cur_req = q;
        cmd <= q.c;
        process <= q.p;
        target_index <= q.k;
        array_length <= q.n;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic request_t random_request(input bit fill);
        request_t q;
        int sel;
        sel = $urandom_range(99);
        q.fixed = 1'b0;
        q.r = '{default: '0};
        q.p = PROCESS_W'($urandom);
        q.k = KEY_W'($urandom);
        q.c = CMD_SEARCH;
        if (fill)
            q.n = LEN_W'($urandom_range(LEN_MAX, 21'd1000000));
        else if (sel < 50)
            q.n = LEN_W'($urandom_range(64));
        else if (sel < 65)
            q.n = LEN_W'($urandom_range(65536));
        else if (sel < 72)
            q.n = LEN_W'($urandom_range(LEN_MAX));
        else
        begin
            q.n = LEN_W'($urandom);
            q.c = (sel < 84) ? CMD_MAP : (sel < 92) ? CMD_RELEASE : CMD_NONE;
        end
        if (q.c == CMD_SEARCH && $urandom_range(3) == 0)
            q.k = KEY_W'($urandom_range(q.n));
        return q;
    endfunction

    initial
    begin
        request_t rows [14];
        int fill_n;
        int tail;
        errors = 0;
        idle_cycles = 0;
        n_items = 0;
        n_results = 0;
        n_exhausted = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        hold_req = 1'b0;
        in_valid = 1'b0;
        cmd = CMD_SEARCH;
        process = '0;
        target_index = '0;
        array_length = '0;
        for (int i = 0; i < N_PROC * N_ENTRIES; i++)
        begin
            page_valid[i] = 1'b0;
            page_frame[i] = '0;
        end
        for (int i = 0; i < N_FRAMES; i++)
            free_stack[i] = 14'(i);
        frames_avail = N_FRAMES;

        rows[0]  = '{CMD_SEARCH,  4'd5,  21'd0, 21'd0, 1'b1, '{1'b0, 5'd0, 5'd0, 14'd12288}};
        rows[1]  = '{CMD_SEARCH,  4'd5,  21'd7, 21'd1, 1'b1, '{1'b0, 5'd0, 5'd0, 14'd12288}};
        rows[2]  = '{CMD_NONE,    4'd15, '1,    '1,    1'b1, '{1'b0, 5'd0, 5'd0, 14'd12288}};
        rows[3]  = '{CMD_MAP,     4'd0,  21'd0, 21'd0, 1'b1, '{1'b0, 5'd0, 5'd0, 14'd12278}};
        rows[4]  = '{CMD_MAP,     4'd0,  '1,    '1,    1'b1, '{1'b0, 5'd0, 5'd0, 14'd12278}};
        rows[5]  = '{CMD_SEARCH,  4'd0,  21'd0, 21'd2, 1'b1, '{1'b0, 5'd1, 5'd1, 14'd12277}};
        rows[6]  = '{CMD_RELEASE, 4'd0,  21'd0, 21'd0, 1'b1, '{1'b0, 5'd0, 5'd0, 14'd12288}};
        rows[7]  = '{CMD_SEARCH,  4'd15, '1,    LEN_MAX, 1'b0, '{default: '0}};
        rows[8]  = '{CMD_SEARCH,  4'd15, 21'd0, LEN_MAX, 1'b0, '{default: '0}};
        rows[9]  = '{CMD_SEARCH,  4'd3,  '1,    21'd2, 1'b0, '{default: '0}};
        rows[10] = '{CMD_RELEASE, 4'd7,  '1,    '1,    1'b0, '{default: '0}};
        rows[11] = '{CMD_MAP,     4'd15, 21'd0, 21'd0, 1'b0, '{default: '0}};
        rows[12] = '{CMD_SEARCH,  4'd10, 21'd1048576, 21'd1048577, 1'b0, '{default: '0}};
        rows[13] = '{CMD_RELEASE, 4'd15, 21'd0, 21'd0, 1'b0, '{default: '0}};

        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (rows[i])
            send(rows[i]);

        send_idle_pct = 31;
        stall_pct = 52;
        for (int i = 0; i < 150; i++)
        begin
            if (i == 40)
                hold_req = 1'b1;
            send(random_request(1'b0));
        end
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);

        send_idle_pct = 52;
        stall_pct = 31;
        for (int i = 0; i < 150; i++)
            send(random_request(1'b0));

        send_idle_pct = 0;
        stall_pct = 0;
        fill_n = 0;
        tail = 0;
        while (fill_n < 1300 && tail < 25)
        begin
            if ($urandom_range(19) == 0)
                send('{CMD_MAP, PROCESS_W'($urandom), '0, '0, 1'b0, '{default: '0}});
            else
                send(random_request(1'b1));
            fill_n++;
            if (frames_avail == 0)
                tail++;
        end
        for (int p = 0; p < N_PROC; p++)
            send('{CMD_RELEASE, PROCESS_W'(p), '0, '0, 1'b0, '{default: '0}});
        for (int i = 0; i < 40; i++)
            send(random_request(1'b0));
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);

        $display("Accepted %0d items and checked %0d results, %0d of them out of frames.",
                 n_items, n_results, n_exhausted);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: filelist.f
rtl/dpfa_pkg.sv
rtl/dpfa_div.sv
rtl/demand_paging_frame_allocator_core.sv
rtl/dpfa_checker.sv
verif/demand_paging_frame_allocator_core_tb.sv
